>>> hdl/scne_pkg.sv
// Shared constants, types and digit arithmetic for the sheared cell neighbor enumerator.
`default_nettype none
package scne_pkg;

  localparam int DIMENSIONS  = 3;
  localparam int MAX_SIDE    = 64;
  localparam int EMIT_LIMIT  = 30;

  localparam int IDX_W       = 18;
  localparam int CPS_W       = 7;
  localparam int SHIFT_W     = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
  localparam int DIG_W       = $clog2(MAX_SIDE);
  localparam int REM_W       = SIDE_W + 1;
  localparam int CNT_W       = $clog2(EMIT_LIMIT);
  localparam int IDX_STEPS   = IDX_W / 2;
  localparam int SHIFT_STEPS = SHIFT_W / 2;
  localparam int STEP_W      = $clog2(IDX_STEPS);
  localparam int DIM_W       = $clog2(DIMENSIONS);

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR_ON       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR_SHIFT    = 2'd2;

  typedef logic [DIG_W-1:0]  digit_t;
  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [1:0]        trit_t;

  // offset codes: trit value minus one
  localparam trit_t TRIT_MINUS = 2'd0;
  localparam trit_t TRIT_ZERO  = 2'd1;
  localparam trit_t TRIT_PLUS  = 2'd2;

  typedef enum logic [1:0] {
    EDGE_NONE,
    EDGE_LOW,
    EDGE_HIGH
  } boundary_t;

  typedef struct packed {
    side_t side;
    logic  shear_on;
  } cfg_t;

  typedef struct packed {
    digit_t [DIMENSIONS-1:0] digits;
    digit_t                  shift;
    boundary_t               boundary;
  } work_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_SHIFT,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_REGULAR,
    B_EXTRA
  } back_state_t;

  function automatic side_t side_clamp(logic [CPS_W-1:0] cps);
    side_t s;
    if (cps == '0) s = SIDE_W'(1);
    else if (int'(cps) > MAX_SIDE) s = SIDE_W'(MAX_SIDE);
    else s = SIDE_W'(cps);
    return s;
  endfunction

  function automatic digit_t wrap_inc(digit_t v, side_t side);
    side_t s;
    s = SIDE_W'(v) + SIDE_W'(1);
    return (s == side) ? '0 : DIG_W'(s);
  endfunction

  function automatic digit_t wrap_dec(digit_t v, side_t side);
    side_t s;
    s = side - SIDE_W'(1);
    return (v == '0) ? DIG_W'(s) : v - DIG_W'(1);
  endfunction

  // a, b below side
  function automatic digit_t add_mod(digit_t a, digit_t b, side_t side);
    logic [SIDE_W:0] s;
    s = (SIDE_W+1)'(a) + (SIDE_W+1)'(b);
    if (s >= (SIDE_W+1)'(side)) s = s - (SIDE_W+1)'(side);
    return DIG_W'(s);
  endfunction

  function automatic digit_t sub_mod(digit_t a, digit_t b, side_t side);
    logic [SIDE_W:0] s;
    if (a >= b) s = (SIDE_W+1)'(a) - (SIDE_W+1)'(b);
    else s = (SIDE_W+1)'(a) + (SIDE_W+1)'(side) - (SIDE_W+1)'(b);
    return DIG_W'(s);
  endfunction

  function automatic digit_t trit_offset(digit_t v, trit_t t, side_t side);
    digit_t r;
    case (t)
      TRIT_MINUS: r = wrap_dec(v, side);
      TRIT_ZERO:  r = v;
      default:    r = wrap_inc(v, side);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/scne_front.sv
// Front end: takes a cell item, splits it into digits, reduces the shift, classifies the row.
`default_nettype none
module scne_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [scne_pkg::IDX_W-1:0]   cell_index,
  input  wire scne_pkg::cfg_t               cfg,
  input  wire logic [scne_pkg::SHIFT_W-1:0] shear_shift,
  input  wire logic                         full,
  output logic                              busy,
  output logic                              push,
  output scne_pkg::work_t                   push_item
);
  import scne_pkg::*;

  front_state_t            state, state_next;
  logic [IDX_W-1:0]        q;
  side_t                   r;
  logic [STEP_W-1:0]       step;
  logic [DIM_W-1:0]        dsel;
  digit_t [DIMENSIONS-1:0] digits;
  digit_t                  shift;
  boundary_t               boundary;

  // two restoring division steps per cycle
  logic [REM_W-1:0] t1, t2;
  logic             b1, b2;
  side_t            r1, r2;
  logic [IDX_W-1:0] q1, q2;

  always_comb begin
    t1 = {r, q[IDX_W-1]};
    b1 = (t1 >= {1'b0, cfg.side});
    r1 = b1 ? SIDE_W'(t1 - {1'b0, cfg.side}) : SIDE_W'(t1);
    q1 = {q[IDX_W-2:0], b1};
    t2 = {r1, q1[IDX_W-1]};
    b2 = (t2 >= {1'b0, cfg.side});
    r2 = b2 ? SIDE_W'(t2 - {1'b0, cfg.side}) : SIDE_W'(t2);
    q2 = {q1[IDX_W-2:0], b2};
  end

  wire div_done   = (step == STEP_W'(IDX_STEPS - 1));
  wire shift_done = (step == STEP_W'(SHIFT_STEPS - 1));
  wire last_digit = (dsel == DIM_W'(DIMENSIONS - 1));

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (start) state_next = F_DIV;
      F_DIV:   if (div_done && last_digit) state_next = F_SHIFT;
      F_SHIFT: if (shift_done) state_next = F_PUSH;
      F_PUSH:  if (!full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    boundary = EDGE_NONE;
    if (cfg.shear_on) begin
      if (digits[1] == '0) boundary = EDGE_LOW;
      else if (SIDE_W'(digits[1]) == cfg.side - SIDE_W'(1)) boundary = EDGE_HIGH;
    end
  end

  always_comb begin
    busy      = (state != F_IDLE);
    push      = (state == F_PUSH) && !full;
    push_item = '{digits: digits, shift: shift, boundary: boundary};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (start) begin
          q    <= cell_index;
          r    <= '0;
          step <= '0;
          dsel <= '0;
        end
      end
      F_DIV: begin
        q <= q2;
        if (div_done) begin
          digits[dsel] <= DIG_W'(r2);
          r            <= '0;
          step         <= '0;
          if (last_digit) begin
            q <= {shear_shift, (IDX_W - SHIFT_W)'(0)};
          end else begin
            dsel <= dsel + DIM_W'(1);
          end
        end else begin
          r    <= r2;
          step <= step + STEP_W'(1);
        end
      end
      F_SHIFT: begin
        q <= q2;
        if (shift_done) begin
          shift <= DIG_W'(r2);
        end else begin
          r    <= r2;
          step <= step + STEP_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/scne_queue.sv
// Short work queue between the front end and the enumerator.
`default_nettype none
module scne_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire scne_pkg::work_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output scne_pkg::work_t      head
);
  import scne_pkg::*;

  work_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;

  always_comb begin
    full  = (count == QCNT_W'(QDEPTH));
    valid = (count != '0);
    head  = entries[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      if (pop)  rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("queue pop while empty");

endmodule
`default_nettype wire

>>> hdl/scne_back.sv
// Back end: walks the neighbor offsets of one cell and composes each neighbor number.
`default_nettype none
module scne_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire scne_pkg::cfg_t             cfg,
  input  wire logic                       avail,
  input  wire scne_pkg::work_t            head,
  output logic                            pop,
  output logic                            strobe,
  output logic [scne_pkg::IDX_W-1:0]      neighbor_index,
  output logic                            last
);
  import scne_pkg::*;

  back_state_t            state, state_next;
  work_t                  cur;
  trit_t [DIMENSIONS-1:0] trit, trit_inc;
  logic [CNT_W-1:0]       count;

  logic                    all_reg, all_extra, final_elem, emit, emit_last;
  digit_t [DIMENSIONS-1:0] nd;

  always_comb begin
    all_reg   = 1'b1;
    all_extra = 1'b1;
    for (int d = 0; d < DIMENSIONS; d++) begin
      if (trit[d] != TRIT_PLUS) begin
        all_reg = 1'b0;
        if (d >= 2) all_extra = 1'b0;
      end
    end
    final_elem = (state == B_REGULAR) ? (all_reg && cur.boundary == EDGE_NONE) : all_extra;
    emit       = (state != B_IDLE);
    emit_last  = emit && (final_elem || count == CNT_W'(EMIT_LIMIT - 1));
  end

  // offset odometer; extras count over dimensions two and up
  always_comb begin
    logic carry;
    carry    = 1'b1;
    trit_inc = trit;
    for (int d = 0; d < DIMENSIONS; d++) begin
      if (carry && (d >= 2 || state == B_REGULAR)) begin
        if (trit[d] == TRIT_PLUS) begin
          trit_inc[d] = TRIT_MINUS;
        end else begin
          trit_inc[d] = trit[d] + 2'd1;
          carry       = 1'b0;
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < DIMENSIONS; d++) begin
      nd[d] = trit_offset(cur.digits[d], trit[d], cfg.side);
    end
    if (state == B_EXTRA) begin
      if (cur.boundary == EDGE_LOW) begin
        nd[0] = wrap_inc(wrap_inc(add_mod(cur.digits[0], cur.shift, cfg.side), cfg.side),
                         cfg.side);
        nd[1] = DIG_W'(cfg.side - SIDE_W'(1));
      end else begin
        nd[0] = wrap_dec(wrap_dec(sub_mod(cur.digits[0], cur.shift, cfg.side), cfg.side),
                         cfg.side);
        nd[1] = '0;
      end
    end else begin
      // crossing the y boundary drags x along
      if (cur.boundary == EDGE_LOW && trit[1] == TRIT_MINUS) begin
        nd[0] = add_mod(nd[0], cur.shift, cfg.side);
      end else if (cur.boundary == EDGE_HIGH && trit[1] == TRIT_PLUS) begin
        nd[0] = sub_mod(nd[0], cur.shift, cfg.side);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (avail) state_next = B_REGULAR;
      B_REGULAR: begin
        if (emit_last) state_next = avail ? B_REGULAR : B_IDLE;
        else if (all_reg) state_next = B_EXTRA;
      end
      B_EXTRA: if (emit_last) state_next = avail ? B_REGULAR : B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop = avail && (state == B_IDLE || emit_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (pop) count <= '0;
      else if (emit) count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= head;
      trit <= '0;
    end else if (emit) begin
      if (state == B_REGULAR && all_reg) trit <= '0;
      else trit <= trit_inc;
    end
  end

  // Horner composition, one multiply per stage after the first
  logic [DIMENSIONS-1:0]   s_valid, s_last;
  logic [IDX_W-1:0]        s_acc [DIMENSIONS];
  digit_t [DIMENSIONS-1:0] s_dig [DIMENSIONS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= '0;
    end else begin
      s_valid <= {s_valid[DIMENSIONS-2:0], emit};
    end
  end

  always_ff @(posedge clk) begin
    s_last[0] <= emit_last;
    s_acc[0]  <= IDX_W'(nd[DIMENSIONS-1]);
    s_dig[0]  <= nd;
    for (int s = 1; s < DIMENSIONS; s++) begin
      s_last[s] <= s_last[s-1];
      s_acc[s]  <= IDX_W'(s_acc[s-1] * IDX_W'(cfg.side))
                   + IDX_W'(s_dig[s-1][DIMENSIONS-1-s]);
    end
    for (int s = 1; s < DIMENSIONS - 1; s++) begin
      s_dig[s] <= s_dig[s-1];
    end
  end

  always_comb begin
    strobe         = s_valid[DIMENSIONS-1];
    last           = s_last[DIMENSIONS-1];
    neighbor_index = s_acc[DIMENSIONS-1];
  end

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    state != B_IDLE |-> count <= CNT_W'(EMIT_LIMIT - 1))
    else $error("emit count past limit");
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    emit_last |=> (state == B_IDLE || count == '0))
    else $error("cell not closed after last neighbor");

endmodule
`default_nettype wire

>>> hdl/sheared_cell_neighbor_enumerator.sv
// Top level of the sheared cell neighbor enumerator: config registers, front, queue, back.
//
//   port group      dir  signals                          timing
//   ----------      ---  -------                          ------
//   cell command    in   start, cell_index / out busy     taken when start && !busy
//   neighbor result out  strobe, neighbor_index, last     one strobe per item, no stall
//   config write    in   cfg_write, cfg_addr, cfg_data    taken when cfg_write is high
//
// The front takes a cell, has its radix-4 divider peel off one digit at a time, reduces the
//   shift, then pushes the item into the queue, waiting while the queue is full.
// The back emits one neighbor per cycle (27 regular, plus 3 extra on a sheared boundary
//   row, at most 30) and each result leaves through the registered Horner chain.
// A two-entry queue lets the front split the next cell while the back is still emitting.
// Reset is synchronous: config goes to side 8, shear off, shift 0; the queue empties.
// The result side cannot stall; busy only covers the front, so a start may land while
//   earlier neighbors are still streaming out.
`default_nettype none
module sheared_cell_neighbor_enumerator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [scne_pkg::IDX_W-1:0]      cell_index,
  output logic                                 strobe,
  output logic [scne_pkg::IDX_W-1:0]           neighbor_index,
  output logic                                 last,
  input  wire logic                            cfg_write,
  input  wire logic [scne_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [scne_pkg::CFG_DATA_W-1:0] cfg_data
);
  import scne_pkg::*;

  // config registers; indexes past the list are dropped
  logic [CPS_W-1:0]   cells_per_side;
  logic               shear_on;
  logic [SHIFT_W-1:0] shear_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_per_side <= CPS_W'(8);
      shear_on       <= 1'b0;
      shear_shift    <= '0;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_CELLS_PER_SIDE: cells_per_side <= cfg_data[CPS_W-1:0];
        REG_SHEAR_ON:       shear_on       <= cfg_data[0];
        REG_SHEAR_SHIFT:    shear_shift    <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // side clamped into 1..MAX_SIDE; shift is reduced per cell in the front
  cfg_t cfg;
  always_comb begin
    cfg.side     = side_clamp(cells_per_side);
    cfg.shear_on = shear_on;
  end

  logic  push, full, pop, avail;
  work_t push_item, head;

  scne_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cell_index (cell_index),
    .cfg        (cfg),
    .shear_shift(shear_shift),
    .full       (full),
    .busy       (busy),
    .push       (push),
    .push_item  (push_item)
  );

  scne_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (full),
    .pop      (pop),
    .valid    (avail),
    .head     (head)
  );

  scne_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .avail         (avail),
    .head          (head),
    .pop           (pop),
    .strobe        (strobe),
    .neighbor_index(neighbor_index),
    .last          (last)
  );

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the sheared cell neighbor enumerator.
`default_nettype none
module testbench;
  import scne_pkg::*;

  // Generous: covers the slowest correct run of roughly 340 items plus config drains.
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 40;
  localparam int MAX_SHOWN = 10;
  // Index 3 is past the register list; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_CELL, ROW_CFG} row_kind_t;

  // One directed row: a cell item or a register write.
  // known_n > 0 means every neighbor is known_idx and there are known_n of them.
  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    addr;
    logic [CFG_DATA_W-1:0]   data;
    logic [IDX_W-1:0]        cell_num;
    logic [5:0]              known_n;
    logic [IDX_W-1:0]        known_idx;
  } stim_row_t;

  typedef struct {
    logic [IDX_W-1:0] nbr;
    logic             last;
    logic [IDX_W-1:0] cell_num;
  } nbr_expect_t;

  localparam int PLAN_ROWS = 33;

  stim_row_t plan [0:PLAN_ROWS-1] = '{
    // reset config: side 8, shear off
    '{ROW_CELL, 2'd0, 7'd0, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd511, 6'd0, 18'd0},
    // index past the grid wraps
    '{ROW_CELL, 2'd0, 7'd0, 18'h3FFFF, 6'd0, 18'd0},
    // side 0 acts as side 1: every neighbor is cell 0
    '{ROW_CFG, REG_CELLS_PER_SIDE, 7'd0, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'h3FFFF, 6'd27, 18'd0},
    // shear on at side one: row 0 is a boundary row, 27 + 3 results, all cell 0
    '{ROW_CFG, REG_SHEAR_ON, 7'd1, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd0, 6'd30, 18'd0},
    '{ROW_CFG, REG_CELLS_PER_SIDE, 7'd1, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd12345, 6'd30, 18'd0},
    // side above the maximum clamps to 64, largest shift
    '{ROW_CFG, REG_SHEAR_SHIFT, 7'd63, 18'd0, 6'd0, 18'd0},
    '{ROW_CFG, REG_CELLS_PER_SIDE, 7'd127, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'h3FFFF, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd327, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd4032, 6'd0, 18'd0},
    // shift of a side or more wraps
    '{ROW_CFG, REG_CELLS_PER_SIDE, 7'd4, 18'd0, 6'd0, 18'd0},
    '{ROW_CFG, REG_SHEAR_SHIFT, 7'd6, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd13, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd63, 6'd0, 18'd0},
    // write past the register list is dropped
    '{ROW_CFG, REG_UNUSED, 7'h7F, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd20, 6'd0, 18'd0},
    // only bit 0 of the shear enable counts
    '{ROW_CFG, REG_SHEAR_ON, 7'h7E, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd0, 6'd0, 18'd0},
    // side 2: both rows are boundary rows
    '{ROW_CFG, REG_CELLS_PER_SIDE, 7'd2, 18'd0, 6'd0, 18'd0},
    '{ROW_CFG, REG_SHEAR_ON, 7'd1, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd2, 6'd0, 18'd0},
    '{ROW_CFG, REG_CELLS_PER_SIDE, 7'd3, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd26, 6'd0, 18'd0},
    // shear on with zero shift
    '{ROW_CFG, REG_CELLS_PER_SIDE, 7'd8, 18'd0, 6'd0, 18'd0},
    '{ROW_CFG, REG_SHEAR_SHIFT, 7'd0, 18'd0, 6'd0, 18'd0},
    '{ROW_CELL, 2'd0, 7'd0, 18'd56, 6'd0, 18'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [IDX_W-1:0]      cell_index = '0;
  logic                  strobe;
  logic [IDX_W-1:0]      neighbor_index;
  logic                  last;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the block's registers.
  logic [CPS_W-1:0]   cps_reg = 7'd8;
  logic               shear_reg = 1'b0;
  logic [SHIFT_W-1:0] shift_reg = '0;

  nbr_expect_t nbr_expect_q [$];
  int          mismatches = 0;
  int          cycle_count = 0;

  sheared_cell_neighbor_enumerator u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cell_index     (cell_index),
    .strobe         (strobe),
    .neighbor_index (neighbor_index),
    .last           (last),
    .cfg_write      (cfg_write),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  function automatic int eff_side(logic [CPS_W-1:0] cps);
    int s;
    s = int'(cps);
    if (s < 1) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s;
  endfunction

  // floored modulo
  function automatic int wrap_mod(int v, int m);
    int r;
    r = v % m;
    if (r < 0) r += m;
    return r;
  endfunction

  // Works out every neighbor of one cell under the shadow config and queues them.
  function automatic void enumerate_neighbors(logic [IDX_W-1:0] cell_num);
    int side, shift, rem, n, k, d, j, pw, delta, dy, idx, cnt;
    int dig [DIMENSIONS];
    int nd [DIMENSIONS];
    boundary_t bnd;
    logic [IDX_W-1:0] found [$];
    nbr_expect_t e;
    side = eff_side(cps_reg);
    rem = int'(cell_num);
    for (d = 0; d < DIMENSIONS; d++) begin
      dig[d] = rem % side;
      rem = rem / side;
    end
    shift = int'(shift_reg) % side;
    bnd = EDGE_NONE;
    if (shear_reg) begin
      // side one: row 0 wins over row side-1
      if (dig[1] == 0) bnd = EDGE_LOW;
      else if (dig[1] == side - 1) bnd = EDGE_HIGH;
    end
    for (n = 0; n < 3 ** DIMENSIONS; n++) begin
      dy = 0;
      pw = 1;
      for (d = 0; d < DIMENSIONS; d++) begin
        delta = (n / pw) % 3 - 1;
        if (d == 1) dy = delta;
        nd[d] = wrap_mod(dig[d] + delta, side);
        pw = pw * 3;
      end
      // x slips only when y actually wraps across the sheared boundary
      if (bnd == EDGE_LOW && dy == -1) nd[0] = wrap_mod(nd[0] + shift, side);
      else if (bnd == EDGE_HIGH && dy == 1) nd[0] = wrap_mod(nd[0] - shift, side);
      idx = 0;
      for (d = DIMENSIONS - 1; d >= 0; d--) idx = idx * side + nd[d];
      found.push_back(IDX_W'(idx));
    end
    if (bnd != EDGE_NONE) begin
      for (k = 0; k < 3 ** (DIMENSIONS - 2); k++) begin
        if (bnd == EDGE_LOW) begin
          nd[0] = wrap_mod(dig[0] + 2 + shift, side);
          nd[1] = side - 1;
        end else begin
          nd[0] = wrap_mod(dig[0] - 2 - shift, side);
          nd[1] = 0;
        end
        for (d = 2; d < DIMENSIONS; d++) begin
          pw = 1;
          for (j = 0; j < d - 2; j++) pw = pw * 3;
          nd[d] = wrap_mod(dig[d] + (k / pw) % 3 - 1, side);
        end
        idx = 0;
        for (d = DIMENSIONS - 1; d >= 0; d--) idx = idx * side + nd[d];
        found.push_back(IDX_W'(idx));
      end
    end
    // anything past the emit limit is dropped
    cnt = (found.size() > EMIT_LIMIT) ? EMIT_LIMIT : found.size();
    for (n = 0; n < cnt; n++) begin
      e.nbr = found[n];
      e.last = (n == cnt - 1);
      e.cell_num = cell_num;
      nbr_expect_q.push_back(e);
    end
  endfunction

  // Raises start with the item and returns at the edge that takes it.
  // start is left high so a back-to-back item needs no second assignment.
  task automatic drive_cell(input logic [IDX_W-1:0] cell_num, input int known_n,
                            input logic [IDX_W-1:0] known_idx);
    nbr_expect_t e;
    int n;
    start <= 1'b1;
    cell_index <= cell_num;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (known_n > 0) begin
      for (n = 0; n < known_n; n++) begin
        e.nbr = known_idx;
        e.last = (n == known_n - 1);
        e.cell_num = cell_num;
        nbr_expect_q.push_back(e);
      end
    end else begin
      enumerate_neighbors(cell_num);
    end
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (addr)
      REG_CELLS_PER_SIDE: cps_reg = data;
      REG_SHEAR_ON:       shear_reg = data[0];
      REG_SHEAR_SHIFT:    shift_reg = data[SHIFT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Block is idle once every neighbor is out; a few spare cycles cover the output chain.
  task automatic drain_neighbors();
    start <= 1'b0;
    while (nbr_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result checker: the block cannot be stalled, so every strobe is consumed here.
  always @(posedge clk) begin
    nbr_expect_t e;
    if (!rst && strobe === 1'b1) begin
      if (nbr_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected neighbor %h last %b", neighbor_index, last);
      end else begin
        e = nbr_expect_q.pop_front();
        if (neighbor_index !== e.nbr || last !== e.last) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("cell %h: expected neighbor %h last %b, got %h last %b",
                     e.cell_num, e.nbr, e.last, neighbor_index, last);
        end
      end
    end
  end

  initial begin
    int r, ph, i, gap, es, x, y, z;
    logic [CFG_DATA_W-1:0] sd;
    logic [IDX_W-1:0] c;
    stim_row_t row;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (r = 0; r < PLAN_ROWS; r++) begin
      row = plan[r];
      if (row.kind == ROW_CFG) begin
        drain_neighbors();
        cfg_put(row.addr, row.data);
      end else begin
        gap = $urandom_range(0, 11);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        drive_cell(row.cell_num, int'(row.known_n), row.known_idx);
      end
    end

    // random phases, each with a fresh config; most keep shear on so boundary rows matter
    for (ph = 0; ph < PHASES; ph++) begin
      drain_neighbors();
      case (ph)
        0:       sd = 7'd4;
        1:       sd = 7'd64;
        2:       sd = 7'($urandom_range(65, 127));
        3:       sd = 7'($urandom_range(0, 127));
        default: sd = 7'($urandom_range(5, 63));
      endcase
      cfg_put(REG_CELLS_PER_SIDE, sd);
      sd = 7'($urandom_range(0, 127));
      if (ph != 6) sd[0] = 1'b1;
      cfg_put(REG_SHEAR_ON, sd);
      case (ph)
        0:       sd = 7'd63;
        1:       sd = 7'd0;
        default: sd = 7'($urandom_range(0, 127));
      endcase
      cfg_put(REG_SHEAR_SHIFT, sd);
      es = eff_side(cps_reg);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // phase 4 runs back to back
        gap = (ph == 4 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 9) < 3) begin
          c = IDX_W'($urandom);
        end else begin
          // built from digits, y biased to the boundary rows
          x = $urandom_range(0, es - 1);
          case ($urandom_range(0, 2))
            0:       y = 0;
            1:       y = es - 1;
            default: y = $urandom_range(0, es - 1);
          endcase
          z = $urandom_range(0, es - 1);
          c = IDX_W'(x + es * (y + es * z));
        end
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        drive_cell(c, 0, '0);
      end
    end

    drain_neighbors();
    repeat (32) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
